>>> src/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types and constants of the four-level page table mapper: command
// and result beats, pool status flags, codes and entry bit positions.
// ----------------------------------------------------------------------------
package fpt_pkg;

    localparam int POOL_FRAMES_DEF = 64;
    localparam int TABLE_ENTRIES   = 512;
    localparam int ENTRY_IDX_W     = 9;
    localparam int PAGE_SHIFT      = 12;
    localparam int PA_W            = 52;
    localparam int VA_W            = 48;
    localparam int PFN_W           = PA_W - PAGE_SHIFT;
    localparam int ENTRY_W         = 64;
    localparam int FLAGS_W         = 12;
    localparam int POOL_CFG_W      = 7;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = PA_W;

    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_MAP   = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_FRAME = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FRAMES = 2'd1;

    localparam int ENTRY_P_BIT = 0;
    localparam logic [ENTRY_W-1:0] ENTRY_P  = 64'h1;
    localparam logic [ENTRY_W-1:0] ENTRY_RW = 64'h2;

    typedef struct packed {
        logic [0:0]         opcode;
        logic [PA_W-1:0]    root_table;
        logic [VA_W-1:0]    virt_page;
        logic [PA_W-1:0]    phys_page;
        logic [FLAGS_W-1:0] entry_flags;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [PA_W-1:0]    frame_addr;
        logic [ENTRY_W-1:0] leaf_entry;
        logic [1:0]         tables_made;
    } result_t;

    typedef struct packed {
        logic empty;
        logic hit;
    } pool_flags_t;

endpackage

>>> src/fpt_table_mem.sv
// ----------------------------------------------------------------------------
// fpt_table_mem
// Table entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpt_table_mem #(
    parameter int POOL_FRAMES = fpt_pkg::POOL_FRAMES_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   wr_en,
    input  logic [$clog2(POOL_FRAMES*fpt_pkg::TABLE_ENTRIES)-1:0]  wr_addr,
    input  logic [fpt_pkg::ENTRY_W-1:0]                            wr_data,
    input  logic                                                   rd_en,
    input  logic [$clog2(POOL_FRAMES*fpt_pkg::TABLE_ENTRIES)-1:0]  rd_addr,
    output logic [fpt_pkg::ENTRY_W-1:0]                            rd_data
);

    localparam int DEPTH = POOL_FRAMES * fpt_pkg::TABLE_ENTRIES;

    logic [fpt_pkg::ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/fpt_frame_pool.sv
// ----------------------------------------------------------------------------
// fpt_frame_pool
// Frame pool bookkeeping: pool base, active frame count and allocation
// cursor, plus address-to-frame lookup and next-frame address.
// ----------------------------------------------------------------------------
module fpt_frame_pool #(
    parameter int POOL_FRAMES = fpt_pkg::POOL_FRAMES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr,
    input  logic [fpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               take,
    input  logic [fpt_pkg::PA_W-1:0]           query_addr,
    output logic [$clog2(POOL_FRAMES)-1:0]     query_idx,
    output logic [$clog2(POOL_FRAMES)-1:0]     next_frame,
    output logic [fpt_pkg::PA_W-1:0]           next_addr,
    output fpt_pkg::pool_flags_t               flags
);

    localparam int FW = $clog2(POOL_FRAMES);
    localparam int CW = $clog2(POOL_FRAMES + 1);

    // Frames are only released all at once, so the lowest free frame is
    // always the allocation cursor; free count is active minus cursor.
    logic [fpt_pkg::PFN_W-1:0] base_reg;
    logic [CW-1:0]             active_reg;
    logic [CW-1:0]             next_reg;
    logic [CW-1:0]             active_new;
    logic [fpt_pkg::PFN_W-1:0] diff;

    always_comb
    begin
        if (32'(cfg_data[fpt_pkg::POOL_CFG_W-1:0]) > POOL_FRAMES)
        begin
            active_new = CW'(POOL_FRAMES);
        end
        else
        begin
            active_new = CW'(cfg_data[fpt_pkg::POOL_CFG_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            active_reg <= '0;
            next_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                fpt_pkg::CFG_POOL_BASE:
                begin
                    base_reg <= cfg_data[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT];
                end
                fpt_pkg::CFG_POOL_FRAMES:
                begin
                    active_reg <= active_new;
                    next_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (take)
        begin
            next_reg <= CW'(next_reg + 1'b1);
        end
    end

    assign diff       = query_addr[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT] - base_reg;
    assign query_idx  = diff[FW-1:0];
    assign next_frame = next_reg[FW-1:0];
    assign next_addr  = {base_reg + fpt_pkg::PFN_W'(next_reg),
                         fpt_pkg::PAGE_SHIFT'(0)};
    assign flags.hit   = diff < fpt_pkg::PFN_W'(active_reg);
    assign flags.empty = next_reg == active_reg;

endmodule

>>> src/four_level_page_table_mapper.sv
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// Builds four-level page tables in a frame pool: alloc and map commands,
// table walk through an entry store with registered read data, new tables cleared.
// ----------------------------------------------------------------------------
// Each new table, whether taken by alloc or by map for a missing level, is
// zeroed one entry per cycle through the single store write port; an alloc
// with no free frame clears nothing.
// One command at a time: busy stays high until the done strobe cycle.
// The result is shown for one cycle with done; the receiver cannot stall.
// Reset empties the pool; the table store is not cleared.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper #(
    parameter int POOL_FRAMES = fpt_pkg::POOL_FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  fpt_pkg::cmd_t                   cmd,
    output logic                            done,
    output fpt_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int FW = $clog2(POOL_FRAMES);
    localparam int AW = $clog2(POOL_FRAMES * fpt_pkg::TABLE_ENTRIES);
    localparam int IW = fpt_pkg::ENTRY_IDX_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_LINK   = 3'd5;
    localparam logic [2:0] S_LEAF   = 3'd6;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;

    logic [2:0]                   state_reg, state_next;
    logic                         done_reg, done_next;
    fpt_pkg::cmd_t                cmd_reg, cmd_next;
    fpt_pkg::result_t             result_reg, result_next;
    logic [FW-1:0]                cur_reg, cur_next;
    logic [FW-1:0]                new_frame_reg, new_frame_next;
    logic [fpt_pkg::PA_W-1:0]     new_addr_reg, new_addr_next;
    logic [IW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [1:0]                   lvl_reg, lvl_next;
    logic [1:0]                   made_reg, made_next;

    logic                         cfg_wr;
    logic                         take;
    logic [fpt_pkg::PA_W-1:0]     query_addr;
    logic [FW-1:0]                query_idx;
    logic [FW-1:0]                next_frame;
    logic [fpt_pkg::PA_W-1:0]     next_addr;
    fpt_pkg::pool_flags_t         pool_flags;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [fpt_pkg::ENTRY_W-1:0]  mem_wdata;
    logic                         mem_re;
    logic [fpt_pkg::ENTRY_W-1:0]  mem_rdata;

    logic [IW-1:0]                vidx;
    logic [fpt_pkg::ENTRY_W-1:0]  link_entry;
    logic [fpt_pkg::ENTRY_W-1:0]  leaf_entry;

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = !busy;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign done      = done_reg;
    assign result    = result_reg;

    fpt_frame_pool #(
        .POOL_FRAMES (POOL_FRAMES)
    ) u_pool (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .query_addr (query_addr),
        .query_idx  (query_idx),
        .next_frame (next_frame),
        .next_addr  (next_addr),
        .flags      (pool_flags)
    );

    fpt_table_mem #(
        .POOL_FRAMES (POOL_FRAMES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr ({cur_reg, vidx}),
        .rd_data (mem_rdata)
    );

    always_comb
    begin
        case (lvl_reg)
            LVL_PML4: vidx = cmd_reg.virt_page[47:39];
            LVL_PDPT: vidx = cmd_reg.virt_page[38:30];
            default:  vidx = cmd_reg.virt_page[29:21];
        endcase
    end

    assign link_entry = {fpt_pkg::PAGE_SHIFT'(0),
                         new_addr_reg[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT],
                         fpt_pkg::PAGE_SHIFT'(0)}
                        | fpt_pkg::ENTRY_P | fpt_pkg::ENTRY_RW
                        | fpt_pkg::ENTRY_W'(cmd_reg.entry_flags);
    assign leaf_entry = {fpt_pkg::PAGE_SHIFT'(0),
                         cmd_reg.phys_page[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT],
                         fpt_pkg::PAGE_SHIFT'(0)}
                        | fpt_pkg::ENTRY_W'(cmd_reg.entry_flags);

    assign query_addr = (state_reg == S_DECODE) ? cmd_reg.root_table
                                                : mem_rdata[fpt_pkg::PA_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        cmd_next       = cmd_reg;
        result_next    = result_reg;
        cur_next       = cur_reg;
        new_frame_next = new_frame_reg;
        new_addr_next  = new_addr_reg;
        clr_cnt_next   = clr_cnt_reg;
        lvl_next       = lvl_reg;
        made_next      = made_reg;
        take           = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = {cur_reg, vidx};
        mem_wdata      = link_entry;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    made_next  = '0;
                    lvl_next   = LVL_PML4;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (cmd_reg.opcode == fpt_pkg::OP_ALLOC)
                begin
                    if (pool_flags.empty)
                    begin
                        result_next        = '0;
                        result_next.status = fpt_pkg::ST_NO_FRAME;
                        done_next          = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        take           = 1'b1;
                        new_frame_next = next_frame;
                        new_addr_next  = next_addr;
                        clr_cnt_next   = '0;
                        state_next     = S_CLEAR;
                    end
                end
                else if (!pool_flags.hit)
                begin
                    result_next        = '0;
                    result_next.status = fpt_pkg::ST_OUTSIDE;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    cur_next   = query_idx;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!mem_rdata[fpt_pkg::ENTRY_P_BIT])
                begin
                    if (pool_flags.empty)
                    begin
                        result_next             = '0;
                        result_next.status      = fpt_pkg::ST_NO_FRAME;
                        result_next.tables_made = made_reg;
                        done_next               = 1'b1;
                        state_next              = S_IDLE;
                    end
                    else
                    begin
                        take           = 1'b1;
                        made_next      = 2'(made_reg + 2'd1);
                        new_frame_next = next_frame;
                        new_addr_next  = next_addr;
                        clr_cnt_next   = '0;
                        state_next     = S_CLEAR;
                    end
                end
                else if (!pool_flags.hit)
                begin
                    result_next             = '0;
                    result_next.status      = fpt_pkg::ST_OUTSIDE;
                    result_next.tables_made = made_reg;
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
                else
                begin
                    cur_next = query_idx;
                    if (lvl_reg == LVL_PD)
                    begin
                        state_next = S_LEAF;
                    end
                    else
                    begin
                        lvl_next   = 2'(lvl_reg + 2'd1);
                        state_next = S_READ;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = {new_frame_reg, clr_cnt_reg};
                mem_wdata    = '0;
                clr_cnt_next = IW'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == IW'(fpt_pkg::TABLE_ENTRIES - 1))
                begin
                    if (cmd_reg.opcode == fpt_pkg::OP_ALLOC)
                    begin
                        result_next            = '0;
                        result_next.status     = fpt_pkg::ST_DONE;
                        result_next.frame_addr = new_addr_reg;
                        done_next              = 1'b1;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
            end
            S_LINK:
            begin
                mem_we   = 1'b1;
                cur_next = new_frame_reg;
                if (lvl_reg == LVL_PD)
                begin
                    state_next = S_LEAF;
                end
                else
                begin
                    lvl_next   = 2'(lvl_reg + 2'd1);
                    state_next = S_READ;
                end
            end
            S_LEAF:
            begin
                mem_we                  = 1'b1;
                mem_waddr               = {cur_reg, cmd_reg.virt_page[20:12]};
                mem_wdata               = leaf_entry;
                result_next             = '0;
                result_next.status      = fpt_pkg::ST_DONE;
                result_next.leaf_entry  = leaf_entry;
                result_next.tables_made = made_reg;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        result_reg    <= result_next;
        cur_reg       <= cur_next;
        new_frame_reg <= new_frame_next;
        new_addr_reg  <= new_addr_next;
        clr_cnt_reg   <= clr_cnt_next;
        lvl_reg       <= lvl_next;
        made_reg      <= made_next;
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe held for more than one cycle");

    a_mem_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("entry store read and written in the same cycle");

    a_take_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !pool_flags.empty)
        else $error("frame taken from an empty pool");

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> ($past(state_reg) == S_READ))
        else $error("entry evaluated without a read issued the cycle before");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != fpt_pkg::ST_DONE)
            |-> (result.frame_addr == '0 && result.leaf_entry == '0))
        else $error("error result carries a frame address or leaf entry");

endmodule

>>> bench/four_level_page_table_mapper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_tb
// Self-checking bench for the page table mapper. A directed run covers the
// empty pool, an address wrap at the top of the physical space, table hits,
// exhaustion in the middle of a walk, pointers that leave the pool after the
// pool moves, and oversized pool sizes. Random phases follow, each starting
// from a new pool setup. A local model of the pool and the table frames
// predicts every result beat, and the monitor compares each one.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper_tb;

    localparam int POOL_N = fpt_pkg::POOL_FRAMES_DEF;
    localparam logic [fpt_pkg::PA_W-1:0] TOP_BASE = 52'hF_FFFF_FFFF_E000;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    fpt_pkg::cmd_t                  cmd;
    logic                           done;
    fpt_pkg::result_t               res_beat;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fpt_pkg::CFG_DATA_W-1:0] cfg_data;

    four_level_page_table_mapper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (res_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model of the pool
    logic [fpt_pkg::PA_W-1:0]    pool_base_q;
    int                          frames_active;
    int                          free_cnt;
    bit [POOL_N-1:0]             used_map;
    bit [POOL_N-1:0]             written;
    bit [fpt_pkg::ENTRY_W-1:0]   table_mem [0:POOL_N*fpt_pkg::TABLE_ENTRIES-1];

    fpt_pkg::cmd_t    cmds_queued [$];
    fpt_pkg::result_t outcomes_due [$];
    fpt_pkg::result_t want;
    logic [26:0] hot_va [0:5];
    bit      cmd_accepted;
    bit      no_gaps;
    int      mismatches;
    int      ph;
    int      i;
    int      kind;
    int      pick;
    logic [fpt_pkg::PA_W-1:0] delta;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [fpt_pkg::PA_W-1:0] rnd52();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[fpt_pkg::PA_W-1:0];
    endfunction

    function automatic logic [fpt_pkg::FLAGS_W-1:0] rnd_flags();
        logic [31:0] v;
        v = $urandom;
        return v[fpt_pkg::FLAGS_W-1:0];
    endfunction

    function automatic logic [fpt_pkg::PA_W-1:0] frame_base(int k);
        logic [fpt_pkg::PA_W-1:0] off;
        off = fpt_pkg::PA_W'(k);
        return pool_base_q + (off << fpt_pkg::PAGE_SHIFT);
    endfunction

    function automatic int frame_index(logic [fpt_pkg::PA_W-1:0] a);
        logic [fpt_pkg::PA_W-1:0] diff;
        int k;
        diff = {a[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT], 12'h000} - pool_base_q;
        if (diff[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT] < frames_active)
        begin
            k = int'(diff[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT]);
            return k;
        end
        return -1;
    endfunction

    function automatic int take_frame();
        int k;
        int j;
        if (free_cnt == 0)
            return -1;
        for (k = 0; k < frames_active; k++)
        begin
            if (!used_map[k])
            begin
                used_map[k] = 1'b1;
                written[k]  = 1'b1;
                free_cnt--;
                for (j = 0; j < fpt_pkg::TABLE_ENTRIES; j++)
                    table_mem[k*fpt_pkg::TABLE_ENTRIES + j] = '0;
                return k;
            end
        end
        return -1;
    endfunction

    // walk the tables and build the result of one command
    function automatic fpt_pkg::result_t mapper_outcome(fpt_pkg::cmd_t c);
        fpt_pkg::result_t            r;
        int                          cur;
        int                          k;
        int                          lvl;
        int                          slot;
        logic [fpt_pkg::ENTRY_W-1:0] e;
        logic [fpt_pkg::PA_W-1:0]    fa;
        r = '0;
        if (c.opcode == fpt_pkg::OP_ALLOC)
        begin
            k = take_frame();
            if (k < 0)
                r.status = fpt_pkg::ST_NO_FRAME;
            else
                r.frame_addr = frame_base(k);
            return r;
        end
        cur = frame_index(c.root_table);
        if (cur < 0)
        begin
            r.status = fpt_pkg::ST_OUTSIDE;
            return r;
        end
        for (lvl = 0; lvl < 3; lvl++)
        begin
            slot = cur*fpt_pkg::TABLE_ENTRIES
                   + c.virt_page[39 - 9*lvl +: fpt_pkg::ENTRY_IDX_W];
            e = table_mem[slot];
            if (!e[fpt_pkg::ENTRY_P_BIT])
            begin
                k = take_frame();
                if (k < 0)
                begin
                    r.status = fpt_pkg::ST_NO_FRAME;
                    return r;
                end
                r.tables_made = r.tables_made + 2'd1;
                fa = frame_base(k);
                e = {12'h000, fa[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT], 12'h000}
                    | fpt_pkg::ENTRY_P | fpt_pkg::ENTRY_RW
                    | {52'h0, c.entry_flags};
                table_mem[slot] = e;
            end
            cur = frame_index(e[fpt_pkg::PA_W-1:0]);
            if (cur < 0)
            begin
                r.status = fpt_pkg::ST_OUTSIDE;
                return r;
            end
        end
        e = {12'h000, c.phys_page[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT], 12'h000}
            | {52'h0, c.entry_flags};
        table_mem[cur*fpt_pkg::TABLE_ENTRIES + c.virt_page[20:12]] = e;
        r.leaf_entry = e;
        return r;
    endfunction

    // false when the walk would read a frame never allocated since reset
    function automatic bit walk_safe(fpt_pkg::cmd_t c);
        int cur;
        int lvl;
        logic [fpt_pkg::ENTRY_W-1:0] e;
        if (c.opcode == fpt_pkg::OP_ALLOC)
            return 1'b1;
        cur = frame_index(c.root_table);
        if (cur < 0)
            return 1'b1;
        for (lvl = 0; lvl < 3; lvl++)
        begin
            if (!written[cur])
                return 1'b0;
            e = table_mem[cur*fpt_pkg::TABLE_ENTRIES
                          + c.virt_page[39 - 9*lvl +: fpt_pkg::ENTRY_IDX_W]];
            if (!e[fpt_pkg::ENTRY_P_BIT])
                return 1'b1;
            cur = frame_index(e[fpt_pkg::PA_W-1:0]);
            if (cur < 0)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic fpt_pkg::cmd_t mk(logic [0:0] op, logic [fpt_pkg::PA_W-1:0] root,
                                         logic [fpt_pkg::VA_W-1:0] va,
                                         logic [fpt_pkg::PA_W-1:0] pa,
                                         logic [fpt_pkg::FLAGS_W-1:0] fl);
        fpt_pkg::cmd_t c;
        c.opcode      = op;
        c.root_table  = root;
        c.virt_page   = va;
        c.phys_page   = pa;
        c.entry_flags = fl;
        return c;
    endfunction

    function automatic logic [fpt_pkg::VA_W-1:0] rnd_va();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[fpt_pkg::VA_W-1:0];
    endfunction

    function automatic fpt_pkg::cmd_t random_cmd();
        fpt_pkg::cmd_t            c;
        int                       k;
        int                       tries;
        int                       sel;
        logic [fpt_pkg::VA_W-1:0] va;
        logic [26:0]              hot;
        c.opcode      = ($urandom_range(99) < 30) ? fpt_pkg::OP_ALLOC : fpt_pkg::OP_MAP;
        c.phys_page   = rnd52();
        c.entry_flags = rnd_flags();
        va  = rnd_va();
        hot = hot_va[$urandom_range(5)];
        sel = $urandom_range(99);
        if (sel < 50)
            va[47:21] = hot;
        else if (sel < 75)
            va[47:39] = hot[26:18];
        c.virt_page = va;
        if ($urandom_range(99) < 85)
        begin
            k = $urandom_range(frames_active);
            for (tries = 0; tries < 8 && k < frames_active && !written[k]; tries++)
                k = $urandom_range(frames_active);
            c.root_table = frame_base(k) | {40'h0, rnd_flags()};
        end
        else
            c.root_table = rnd52();
        return c;
    endfunction

    function automatic logic [fpt_pkg::CFG_DATA_W-1:0] frames_word(
        logic [fpt_pkg::POOL_CFG_W-1:0] v);
        logic [fpt_pkg::CFG_DATA_W-1:0] w;
        w = rnd52();
        w[fpt_pkg::POOL_CFG_W-1:0] = v;
        return w;
    endfunction

    task automatic send(fpt_pkg::cmd_t c);
        if (walk_safe(c))
        begin
            outcomes_due.push_back(mapper_outcome(c));
            cmds_queued.push_back(c);
        end
    endtask

    task automatic drain();
        while (cmds_queued.size() != 0 || outcomes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [fpt_pkg::CFG_IDX_W-1:0] idx,
                             logic [fpt_pkg::CFG_DATA_W-1:0] val);
        int n;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == fpt_pkg::CFG_POOL_BASE)
            pool_base_q = {val[fpt_pkg::PA_W-1:fpt_pkg::PAGE_SHIFT], 12'h000};
        else if (idx == fpt_pkg::CFG_POOL_FRAMES)
        begin
            n = int'(val[fpt_pkg::POOL_CFG_W-1:0]);
            frames_active = (n > POOL_N) ? POOL_N : n;
            free_cnt      = frames_active;
            used_map      = '0;
        end
    endtask

    // driver: hold a raised start until the beat is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_accepted)
                void'(cmds_queued.pop_front());
            if (cmds_queued.size() != 0 &&
                ((start && !cmd_accepted) || no_gaps || $urandom_range(99) >= 37))
            begin
                start <= 1'b1;
                cmd   <= cmds_queued[0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cmd_accepted = rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (outcomes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with none pending: %h", $time, res_beat);
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (res_beat.status !== want.status || res_beat.frame_addr !== want.frame_addr ||
                    res_beat.leaf_entry !== want.leaf_entry ||
                    res_beat.tables_made !== want.tables_made)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("%0t: mismatch exp/got status %0d/%0d frame %h/%h ", $time,
                               want.status, res_beat.status,
                               want.frame_addr, res_beat.frame_addr);
                        $display("leaf %h/%h tables %0d/%0d",
                                 want.leaf_entry, res_beat.leaf_entry,
                                 want.tables_made, res_beat.tables_made);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = '0;
        cfg_valid     = 1'b0;
        cfg_index     = fpt_pkg::CFG_POOL_BASE;
        cfg_data      = '0;
        cmd_accepted  = 1'b0;
        no_gaps       = 1'b0;
        mismatches    = 0;
        pool_base_q   = '0;
        frames_active = 0;
        free_cnt      = 0;
        used_map      = '0;
        written       = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // empty pool out of reset
        send(mk(fpt_pkg::OP_ALLOC, rnd52(), rnd_va(), rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, '0, '1, '1, 12'hFFF));
        drain();

        // pool at the top of the address space: frames wrap to zero
        write_reg(fpt_pkg::CFG_POOL_BASE, TOP_BASE | {40'h0, rnd_flags()});
        write_reg(fpt_pkg::CFG_POOL_FRAMES, frames_word(7'd5));
        send(mk(fpt_pkg::OP_ALLOC, rnd52(), rnd_va(), rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, frame_base(0) | 52'hFFF, '1, '1, 12'hFFF));
        send(mk(fpt_pkg::OP_MAP, frame_base(0), '1, '0, '0));
        send(mk(fpt_pkg::OP_MAP, frame_base(0), '0, rnd52(), 12'h001));
        send(mk(fpt_pkg::OP_ALLOC, rnd52(), rnd_va(), rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, frame_base(0) - 52'h1000, rnd_va(), rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, frame_base(5), rnd_va(), rnd52(), rnd_flags()));
        drain();

        // move the pool: old entries now point outside or into other frames
        write_reg(fpt_pkg::CFG_POOL_BASE, TOP_BASE + 52'h2000);
        send(mk(fpt_pkg::OP_MAP, frame_base(0), '1, rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, frame_base(0), '0, rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_ALLOC, rnd52(), rnd_va(), rnd52(), rnd_flags()));
        drain();

        // oversized pool, frames freed but old tables kept
        write_reg(fpt_pkg::CFG_POOL_FRAMES, frames_word(7'd127));
        write_reg(fpt_pkg::CFG_POOL_BASE, TOP_BASE);
        send(mk(fpt_pkg::OP_MAP, frame_base(0), '1, rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_ALLOC, rnd52(), rnd_va(), rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, frame_base(1), '1, rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, frame_base(0), rnd_va(), rnd52(), rnd_flags()));
        drain();

        write_reg(fpt_pkg::CFG_POOL_FRAMES, frames_word(7'd0));
        send(mk(fpt_pkg::OP_ALLOC, rnd52(), rnd_va(), rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, frame_base(0), rnd_va(), rnd52(), rnd_flags()));
        drain();

        write_reg(fpt_pkg::CFG_POOL_FRAMES, frames_word(7'd1));
        send(mk(fpt_pkg::OP_ALLOC, rnd52(), rnd_va(), rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_ALLOC, rnd52(), rnd_va(), rnd52(), rnd_flags()));
        send(mk(fpt_pkg::OP_MAP, frame_base(0), rnd_va(), rnd52(), rnd_flags()));
        drain();

        for (ph = 0; ph < 14; ph++)
        begin
            no_gaps = (ph == 6);
            kind = $urandom_range(2);
            if (kind == 1)
            begin
                delta = fpt_pkg::PA_W'($urandom_range(6));
                write_reg(fpt_pkg::CFG_POOL_BASE,
                          pool_base_q + (delta << fpt_pkg::PAGE_SHIFT) - 52'h3000);
            end
            else if (kind == 2)
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                    write_reg(fpt_pkg::CFG_POOL_BASE, {40'h0, rnd_flags()});
                else if (pick < 40)
                    write_reg(fpt_pkg::CFG_POOL_BASE, TOP_BASE | {40'h0, rnd_flags()});
                else
                    write_reg(fpt_pkg::CFG_POOL_BASE, rnd52());
            end
            if (kind != 1)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    write_reg(fpt_pkg::CFG_POOL_FRAMES, frames_word(7'd64));
                else if (pick < 18)
                    write_reg(fpt_pkg::CFG_POOL_FRAMES,
                              frames_word(7'($urandom_range(127, 65))));
                else if (pick < 22)
                    write_reg(fpt_pkg::CFG_POOL_FRAMES, frames_word(7'd0));
                else
                    write_reg(fpt_pkg::CFG_POOL_FRAMES,
                              frames_word(7'($urandom_range(24, 1))));
            end
            for (i = 0; i < 6; i++)
                hot_va[i] = 27'($urandom);
            for (i = 0; i < 55; i++)
                send(random_cmd());
            drain();
        end

        no_gaps = 1'b0;
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outcomes_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
src/fpt_pkg.sv
src/fpt_table_mem.sv
src/fpt_frame_pool.sv
src/four_level_page_table_mapper.sv
bench/four_level_page_table_mapper_tb.sv
